FILE: rtl/dsc_pkg.sv
// Shared types and constants for the dilated strided 1D convolution block.
// No dependencies; used by dsc_window and dilated_strided_conv1d_top.
package dsc_pkg;

  // defaults for the top-level parameters
  localparam int TAPS_DEF         = 3;
  localparam int MAX_DILATION_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int NUM_COEF  = 5;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SPACE_W   = 4;
  localparam int OUT_W     = 40;
  localparam int MAX_STEP  = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIL    = 3'd6;

  // what the window logic reports for the sample being taken in
  typedef struct packed {
    logic emit;   // sample completes an output window
    logic last;   // sample ends the sequence
  } win_ctl_t;

endpackage

FILE: rtl/dsc_window.sv
// Delay line, window fill and stride counters, and per-tap sample selection.
// Depends on dsc_pkg.
module dsc_window #(
  parameter int TAPS         = dsc_pkg::TAPS_DEF,
  parameter int MAX_DILATION = dsc_pkg::MAX_DILATION_DEF,
  parameter int SAMPLE_BITS  = dsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift_en,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              last,
  input  logic [dsc_pkg::SPACE_W-1:0]       step_size,
  input  logic [dsc_pkg::SPACE_W-1:0]       tap_spacing,
  output logic signed [SAMPLE_BITS-1:0]     tap_o [TAPS],
  output dsc_pkg::win_ctl_t                 ctl
);

  localparam int LINE_DEPTH = MAX_DILATION * (TAPS - 1) + 1;
  localparam int SEEN_W     = $clog2(LINE_DEPTH + 1);
  localparam int DIL_W      = $clog2(MAX_DILATION + 1);

  logic signed [SAMPLE_BITS-1:0] line_r     [LINE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] line_shift [LINE_DEPTH];
  logic [SEEN_W-1:0]             seen_r, seen_nxt, span;
  logic [2:0]                    phase_r, phase_nxt, phase_eff;
  logic [3:0]                    phase_p1;
  logic [dsc_pkg::SPACE_W-1:0]   s_eff;
  logic [DIL_W-1:0]              d_eff;
  logic                          win_full;

  always_comb begin
    if (step_size == '0) begin
      s_eff = dsc_pkg::SPACE_W'(1);
    end else if (int'(step_size) > dsc_pkg::MAX_STEP) begin
      s_eff = dsc_pkg::SPACE_W'(dsc_pkg::MAX_STEP);
    end else begin
      s_eff = step_size;
    end
    if (tap_spacing == '0) begin
      d_eff = DIL_W'(1);
    end else if (int'(tap_spacing) > MAX_DILATION) begin
      d_eff = DIL_W'(MAX_DILATION);
    end else begin
      d_eff = DIL_W'(tap_spacing);
    end
  end

  assign span = SEEN_W'(int'(d_eff) * (TAPS - 1) + 1);

  // fill count saturates at the current span
  assign seen_nxt = (seen_r >= span) ? span : SEEN_W'(seen_r + 1'b1);
  assign win_full = (seen_nxt == span);

  // phase left over from a wider stride wraps to zero
  assign phase_eff = ({1'b0, phase_r} >= s_eff) ? 3'd0 : phase_r;
  assign phase_p1  = {1'b0, phase_eff} + 4'd1;
  assign phase_nxt = (phase_p1 >= s_eff) ? 3'd0 : phase_p1[2:0];

  assign ctl.emit = win_full && (phase_eff == 3'd0);
  assign ctl.last = last;

  always_comb begin
    line_shift[0] = sample;
    for (int i = 1; i < LINE_DEPTH; i++) begin
      line_shift[i] = line_r[i-1];
    end
  end

  // tap j sits d*(TAPS-1-j) samples back; one fixed position per dilation
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      tap_o[j] = '0;
      for (int k = 1; k <= MAX_DILATION; k++) begin
        if (d_eff == DIL_W'(k)) begin
          tap_o[j] = line_shift[k * (TAPS - 1 - j)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_r[i] <= '0;
      end
      seen_r  <= '0;
      phase_r <= '0;
    end else if (shift_en) begin
      if (last) begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
          line_r[i] <= '0;
        end
        seen_r  <= '0;
        phase_r <= '0;
      end else begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
          line_r[i] <= line_shift[i];
        end
        seen_r <= seen_nxt;
        if (win_full) begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

  property p_fill_bounded;
    @(posedge clk) disable iff (!rst_n)
      $past(shift_en) && !$past(last) |-> seen_r <= SEEN_W'(LINE_DEPTH);
  endproperty
  a_fill_bounded: assert property (p_fill_bounded)
    else $error("window fill count beyond delay line depth");

  property p_last_clears;
    @(posedge clk) disable iff (!rst_n)
      shift_en && last |=> seen_r == '0 && phase_r == '0;
  endproperty
  a_last_clears: assert property (p_last_clears)
    else $error("counters not cleared after end of sequence");

  property p_phase_in_range;
    @(posedge clk) disable iff (!rst_n)
      shift_en && win_full && !last |=> {1'b0, phase_r} < $past(s_eff);
  endproperty
  a_phase_in_range: assert property (p_phase_in_range)
    else $error("stride phase outside stride");

endmodule

FILE: rtl/dilated_strided_conv1d_top.sv
// Dilated strided 1D convolution: config registers, multiply-accumulate, output register.
// Depends on dsc_pkg and dsc_window.
//
// Usage:
//   Samples enter on in_valid/in_ready with in_sample and in_last_sample.
//   Results leave on out_valid/out_ready with out_conv_value, out_has_value
//   and out_sequence_end. A sample gives a result when it completes an output
//   window (windows start step_size samples apart, 0 as 1, capped at MAX_STEP,
//   once the span is filled) or when it is marked last; the last sample always
//   gives one result with out_sequence_end set, and then the delay line and
//   counters are cleared. Coefficients, stride and dilation are written on
//   cfg_we/cfg_index/cfg_data and take effect on the next sample.
//   A result is on out_valid the cycle after its sample transfer
//   (tap select, TAPS parallel multiplies and the sum feed the output register
//   directly). Throughput: one sample per cycle while no result waits on a stall.
//   When the receiver stalls with a result waiting, in_ready drops until that
//   result transfers; samples that give no result still load the output data
//   registers but leave out_valid low.
//   Reset (rst_n low, synchronous) clears coefficients to 0, stride and
//   dilation to 1, the delay line and the output valid flag.
module dilated_strided_conv1d_top #(
  parameter int TAPS         = dsc_pkg::TAPS_DEF,
  parameter int MAX_DILATION = dsc_pkg::MAX_DILATION_DEF,
  parameter int SAMPLE_BITS  = dsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dsc_pkg::OUT_W-1:0]    out_conv_value,
  output logic                                out_has_value,
  output logic                                out_sequence_end,
  input  logic                                cfg_we,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + dsc_pkg::COEF_W;
  localparam int SUM_W  = (PROD_W + 3 > dsc_pkg::OUT_W) ? PROD_W + 3 : dsc_pkg::OUT_W;

  logic signed [dsc_pkg::COEF_W-1:0] coef_r [dsc_pkg::NUM_COEF];
  logic [dsc_pkg::SPACE_W-1:0]       step_r, dil_r;

  logic signed [SAMPLE_BITS-1:0] tap  [TAPS];
  logic signed [PROD_W-1:0]      prod [TAPS];
  logic signed [SUM_W-1:0]       sum;
  dsc_pkg::win_ctl_t             ctl;

  logic out_valid_r, out_has_value_r, out_sequence_end_r;
  logic signed [dsc_pkg::OUT_W-1:0] out_conv_value_r;
  logic in_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dsc_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
      step_r <= dsc_pkg::SPACE_W'(1);
      dil_r  <= dsc_pkg::SPACE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        dsc_pkg::REG_STEP: step_r <= cfg_data[dsc_pkg::SPACE_W-1:0];
        dsc_pkg::REG_DIL:  dil_r  <= cfg_data[dsc_pkg::SPACE_W-1:0];
        default: begin
          if (cfg_index <= dsc_pkg::REG_COEF_4) begin
            coef_r[cfg_index] <= cfg_data[dsc_pkg::COEF_W-1:0];
          end
        end
      endcase
    end
  end

  // a waiting result blocks the input until it transfers
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  dsc_window #(
    .TAPS         (TAPS),
    .MAX_DILATION (MAX_DILATION),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (in_xfer),
    .sample      (in_sample),
    .last        (in_last_sample),
    .step_size   (step_r),
    .tap_spacing (dil_r),
    .tap_o       (tap),
    .ctl         (ctl)
  );

  always_comb begin
    sum = '0;
    for (int j = 0; j < TAPS; j++) begin
      prod[j] = tap[j] * coef_r[j];
      sum     = sum + SUM_W'(prod[j]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_xfer && (ctl.emit || ctl.last);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_has_value_r    <= ctl.emit;
      out_sequence_end_r <= ctl.last;
      out_conv_value_r   <= ctl.emit ? sum[dsc_pkg::OUT_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_conv_value   = out_conv_value_r;
  assign out_has_value    = out_has_value_r;
  assign out_sequence_end = out_sequence_end_r;

  property p_result_has_reason;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r |-> out_has_value_r || out_sequence_end_r;
  endproperty
  a_result_has_reason: assert property (p_result_has_reason)
    else $error("result without value and without end marker");

  property p_empty_value_zero;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_has_value_r |-> out_conv_value_r == '0;
  endproperty
  a_empty_value_zero: assert property (p_empty_value_zero)
    else $error("nonzero value on a result without value");

  property p_stalled_result_holds;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_ready |=> out_valid_r && $stable(out_conv_value_r) &&
                                    $stable(out_has_value_r) && $stable(out_sequence_end_r);
  endproperty
  a_stalled_result_holds: assert property (p_stalled_result_holds)
    else $error("waiting result changed under stall");

  property p_ready_when_empty;
    @(posedge clk) disable iff (!rst_n)
      !out_valid_r |-> in_ready;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("input stalled with empty output register");

endmodule
